[sv/mmn_pkg.sv]
// Shared types and constants for the min-max array normalizer.
`default_nettype none
package mmn_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int CODE_W        = 16;
  localparam int NUM_W         = SAMPLE_W + CODE_W;
  localparam int REG_W         = 16;
  localparam int REG_IDX_W     = 1;
  localparam int DEF_SET_DEPTH = 64;

  localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 1'b1;

  localparam logic [REG_W-1:0] OUT_MIN_RESET = 16'd0;
  localparam logic [REG_W-1:0] OUT_MAX_RESET = 16'd255;

  // One classified input word on its way from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
    logic                       keep;
    logic                       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic emitting;
    logic pop;
    logic pop_last;
  } back_stat_t;

endpackage
`default_nettype wire

[sv/mmn_front.sv]
// Front end: accept input words and classify them as first, stored or dropped.
`default_nettype none
module mmn_front import mmn_pkg::*; #(
  parameter int SET_DEPTH = DEF_SET_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output cmd_t                       cmd
);

  localparam int CW = $clog2(SET_DEPTH + 1);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          keep;

  assign keep      = cnt < CW'(SET_DEPTH);
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  assign cmd.sample = sample;
  assign cmd.first  = (cnt == '0);
  assign cmd.keep   = keep;
  assign cmd.last   = last;

  always_comb begin
    cnt_next = cnt;
    if (in_valid && cmd_ready) begin
      if (last) begin
        cnt_next = '0;
      end else if (keep) begin
        cnt_next = cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

[sv/mmn_queue.sv]
// Two-entry word queue between front and back.
`default_nettype none
module mmn_queue import mmn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  cmd_t    push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output cmd_t    pop_data,
  output q_stat_t stat
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/mmn_div.sv]
// Restoring divider, one quotient bit per cycle, for quotients known to fit CODE_W bits.
`default_nettype none
module mmn_div import mmn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [SAMPLE_W-1:0] den,
  output logic                done,
  output logic [CODE_W-1:0]   quo,
  output logic                rem_nz
);

  localparam int SW = $clog2(CODE_W);

  logic [SAMPLE_W:0]   rem;
  logic [CODE_W-1:0]   lo;
  logic [SW-1:0]       steps;
  logic                busy;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   den_ext;
  logic                ge;

  assign den_ext = {1'b0, den};
  assign trial   = {rem[SAMPLE_W-1:0], lo[CODE_W-1]};
  assign ge      = (trial >= den_ext);
  assign rem_nz  = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper bits are already below den since the quotient fits CODE_W bits
        rem   <= {1'b0, num[NUM_W-1:CODE_W]};
        lo    <= num[CODE_W-1:0];
        quo   <= '0;
        steps <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? (trial - den_ext) : trial;
        lo    <= {lo[CODE_W-2:0], 1'b0};
        quo   <= {quo[CODE_W-2:0], ge};
        steps <= steps + SW'(1);
        if (steps == SW'(CODE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/mmn_back.sv]
// Back end: store samples, track min and max, and emit normalized codes.
`default_nettype none
module mmn_back import mmn_pkg::*; #(
  parameter int SET_DEPTH = DEF_SET_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic [REG_W-1:0]  out_min,
  input  logic [REG_W-1:0]  out_max,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] code,
  output logic              final_res,
  output back_stat_t        stat
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  typedef enum logic [2:0] {S_LOAD, S_READ, S_MUL, S_DIV, S_OUT} state_t;

  state_t                     state;
  logic signed [SAMPLE_W-1:0] mem [SET_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic [AW-1:0]              wp;
  logic [AW-1:0]              wa;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              end_idx;
  logic [AW-1:0]              k;
  logic                       pop;
  logic                       out_free;

  logic [SAMPLE_W:0]   diff_w;
  logic [SAMPLE_W:0]   den_w;
  logic [SAMPLE_W-1:0] den;
  logic                den_zero;
  logic                span_neg;
  logic [CODE_W-1:0]   span_mag;
  logic [NUM_W-1:0]    prod;
  logic                div_start;
  logic                div_done;
  logic [CODE_W-1:0]   div_q;
  logic                div_rnz;
  logic [CODE_W-1:0]   q_ceil;
  logic [CODE_W-1:0]   code_calc;

  assign cmd_ready = (state == S_LOAD);
  assign pop       = cmd_valid && cmd_ready;
  assign wa        = cmd.first ? '0 : wp;
  assign out_free  = !out_valid || out_ready;

  assign diff_w   = {rd_data[SAMPLE_W-1], rd_data} - {run_min[SAMPLE_W-1], run_min};
  assign den_w    = {run_max[SAMPLE_W-1], run_max} - {run_min[SAMPLE_W-1], run_min};
  assign den      = den_w[SAMPLE_W-1:0];
  assign den_zero = (run_max == run_min);
  assign span_neg = (out_max < out_min);
  assign span_mag = span_neg ? (out_min - out_max) : (out_max - out_min);
  assign prod     = span_mag * diff_w[SAMPLE_W-1:0];
  assign div_start = (state == S_MUL);

  // floor of a negative quotient is minus the ceiling of its magnitude
  assign q_ceil    = div_q + CODE_W'(div_rnz);
  assign code_calc = den_zero ? out_min :
                     span_neg ? (out_min - q_ceil) : (out_min + div_q);

  assign stat.emitting = (state != S_LOAD);
  assign stat.pop      = pop;
  assign stat.pop_last = pop && cmd.last;

  mmn_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (prod),
    .den    (den),
    .done   (div_done),
    .quo    (div_q),
    .rem_nz (div_rnz)
  );

  always_ff @(posedge clk) begin
    if (pop && cmd.keep) begin
      mem[wa] <= cmd.sample;
    end
    rd_data <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      // in S_OUT a taken word is replaced by the next one below
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (pop) begin
            if (cmd.keep) begin
              wp       <= wa + AW'(1);
              last_idx <= wa;
              if (cmd.first) begin
                run_min <= cmd.sample;
                run_max <= cmd.sample;
              end else begin
                if (cmd.sample < run_min) begin
                  run_min <= cmd.sample;
                end
                if (cmd.sample > run_max) begin
                  run_max <= cmd.sample;
                end
              end
            end
            if (cmd.last) begin
              end_idx <= cmd.keep ? wa : last_idx;
              k       <= '0;
              state   <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            code      <= code_calc;
            final_res <= (k == end_idx);
            if (k == end_idx) begin
              state <= S_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/min_max_array_normalizer.sv]
// Min-max array normalizer top level: config registers, front, queue and back.
// A word passes through the two-entry queue on its way to the back; loading stores one
// sample per cycle while the back is loading. Each result steps through read, multiply,
// divide, a wait for done and output load while the output is free, on the one divider.
// Reset (rst, synchronous, active high) empties queue and counters, drops any pending
// result and restores out_min = 0, out_max = 255; the sample store is not cleared.
`default_nettype none
module min_max_array_normalizer import mmn_pkg::*; #(
  parameter int SET_DEPTH = DEF_SET_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CODE_W-1:0]          code,
  output logic                       final_res,
  input  logic                       cfg_we,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [REG_W-1:0]           cfg_data
);

  logic [REG_W-1:0] out_min;
  logic [REG_W-1:0] out_max;

  cmd_t       f_cmd;
  logic       f_valid;
  logic       f_ready;
  cmd_t       b_cmd;
  logic       b_valid;
  logic       b_ready;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // Configuration writes land directly; unknown indexes fall through untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_min <= OUT_MIN_RESET;
      out_max <= OUT_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUT_MIN: out_min <= cfg_data;
        REG_OUT_MAX: out_max <= cfg_data;
        default: begin
          out_min <= out_min;
        end
      endcase
    end
  end

  // Front: classify each word as first of set, stored, or dropped on a full store.
  mmn_front #(.SET_DEPTH(SET_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .last      (last),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Queue: lets the front take up to two words while the back is busy.
  mmn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd),
    .stat       (q_stat)
  );

  // Back: store, track extremes, then emit one code per stored sample in load order.
  mmn_back #(.SET_DEPTH(SET_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_min   (out_min),
    .out_max   (out_max),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code      (code),
    .final_res (final_res),
    .stat      (b_stat)
  );

  // The back must never drain the queue while it is emitting a set.
  a_no_pop_in_emit: assert property (@(posedge clk) disable iff (rst)
    b_stat.emitting |-> !b_stat.pop)
    else $error("queue popped during emission");

  // A word that closes a set starts emission on the next cycle.
  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    b_stat.pop_last |=> b_stat.emitting)
    else $error("closing word did not start emission");

  // Queue occupancy flags stay consistent.
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

endmodule
`default_nettype wire
